### hw/rtl/q2e_pkg.sv
`timescale 1ns / 1ps

package q2e_pkg;

  // field and datapath widths
  localparam int QW = 32;                 // raw quaternion component
  localparam int WW = 31;                 // scalar part
  localparam int MW = 33;                 // multiplier operand, signed
  localparam int PW = 2 * MW + 1;         // signed product
  localparam int SUMW = 38;               // sum of two Q2.30 products
  localparam int CW = 40;                 // CORDIC vector
  localparam int AW = 33;                 // binary angle, 2^32 per turn
  localparam int RW = 62;                 // square root radicand
  localparam int SW = RW / 2;             // square root result
  localparam int YAWW = 16;
  localparam int PITW = 15;
  localparam int TBL_N = 32;              // arctangent table depth
  localparam int TBLW = 30;
  localparam int CORDIC_STEPS_DEF = 24;

  localparam logic [63:0] ONE_SQ = 64'h1000_0000_0000_0000;   // 1.0 squared in Q4.60
  localparam int CENTIDEG_PER_TURN = 36000;
  localparam logic [YAWW-1:0] YAW_LIM = 16'd18000;
  localparam logic [YAWW-1:0] PITCH_LIM = 16'd9000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_ROOT,
    ST_PR_MUL,
    ST_PT_MUL,
    ST_PT_ROOT,
    ST_CORD,
    ST_CONV,
    ST_DONE
  } state_t;

  function automatic logic [TBLW-1:0] atan_bam(input logic [$clog2(TBL_N)-1:0] idx);
    logic [TBLW-1:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/q2e_in_if.sv
`timescale 1ns / 1ps

interface q2e_in_if import q2e_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 quat_present;
  logic signed [QW-1:0] q1_raw;
  logic signed [QW-1:0] q2_raw;
  logic signed [QW-1:0] q3_raw;

  modport source (output valid, quat_present, q1_raw, q2_raw, q3_raw, input ready);
  modport sink (input valid, quat_present, q1_raw, q2_raw, q3_raw, output ready);
endinterface

### hw/rtl/q2e_out_if.sv
`timescale 1ns / 1ps

interface q2e_out_if import q2e_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [WW-1:0]          quat_w;
  logic signed [QW-1:0]   quat_x;
  logic signed [QW-1:0]   quat_y;
  logic signed [QW-1:0]   quat_z;
  logic signed [YAWW-1:0] yaw_centideg;
  logic signed [PITW-1:0] pitch_centideg;
  logic signed [YAWW-1:0] roll_centideg;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, yaw_centideg,
                  pitch_centideg, roll_centideg, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, yaw_centideg,
                pitch_centideg, roll_centideg, output ready);
endinterface

### hw/rtl/q2e_mul.sv
`timescale 1ns / 1ps

// Bit-serial signed multiplier: one multiplier bit per cycle on magnitudes,
// then a final step restores the sign.
module q2e_mul import q2e_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [MW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic                 done,
  output logic signed [PW-1:0] p
);

  localparam int CNTW = $clog2(MW + 1);

  logic            busy;
  logic            fix;
  logic [CNTW-1:0] cnt;
  logic [MW-1:0]   ma;
  logic [MW-1:0]   mb;
  logic            neg;
  logic [2*MW-1:0] acc;
  logic [MW:0]     sum;

  assign sum = {1'b0, acc[2*MW-1:MW]} + (mb[0] ? {1'b0, ma} : {(MW + 1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy && !fix) begin
        ma   <= a[MW-1] ? MW'(-a) : MW'(a);
        mb   <= b[MW-1] ? MW'(-b) : MW'(b);
        neg  <= a[MW-1] ^ b[MW-1];
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= {sum, acc[MW-1:1]};
        mb  <= mb >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(MW - 1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        p    <= neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

### hw/rtl/q2e_sqrt.sv
`timescale 1ns / 1ps

// Digit-by-digit floor square root: two radicand bits in, one root bit out
// per cycle.
module q2e_sqrt import q2e_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [RW-1:0] rad,
  output logic          done,
  output logic [SW-1:0] root
);

  localparam int CNTW = $clog2(SW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [RW-1:0]   rad_sh;
  logic [SW+1:0]   rem;
  logic [SW+1:0]   rem_sh;
  logic [SW+1:0]   trial;

  assign rem_sh = {rem[SW-1:0], rad_sh[RW-1:RW-2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        rad_sh <= rad;
        rem    <= '0;
        root   <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        rad_sh <= {rad_sh[RW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[SW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[SW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(SW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/q2e_cordic.sv
`timescale 1ns / 1ps

// Vectoring CORDIC atan2, one micro-rotation per cycle.
module q2e_cordic import q2e_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] x_in,
  output logic                 done,
  output logic signed [AW-1:0] ang
);

  localparam int CNTW = $clog2(TBL_N + 1);
  localparam int IW = $clog2(TBL_N);
  localparam logic signed [AW-1:0] QUARTER = AW'(64'd1073741824);

  logic                 busy;
  logic [CNTW-1:0]      cnt;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [AW-1:0] da;

  assign dx = x >>> cnt[IW-1:0];
  assign dy = y >>> cnt[IW-1:0];
  assign da = $signed({{(AW - TBLW){1'b0}}, atan_bam(cnt[IW-1:0])});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        cnt <= '0;
        if (x_in == '0 && y_in == '0) begin
          ang  <= '0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          // pre-rotate a left half-plane vector by a quarter turn
          if (x_in < 0) begin
            if (y_in >= 0) begin
              x   <= y_in;
              y   <= -x_in;
              ang <= QUARTER;
            end else begin
              x   <= -y_in;
              y   <= x_in;
              ang <= -QUARTER;
            end
          end else begin
            x   <= x_in;
            y   <= y_in;
            ang <= '0;
          end
        end
      end else if (busy) begin
        if (!y[CW-1]) begin
          x   <= x + dy;
          y   <= y - dx;
          ang <= ang + da;
        end else begin
          x   <= x - dy;
          y   <= y + dx;
          ang <= ang - da;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/quaternion_to_euler_angles_core.sv
// A sample with quat_present set runs every phase; without it the held quaternion
// is reused and the square and square root phases are skipped.
// Samples are handled one at a time, at a rate set by the one bit-serial multiplier
// that forms all products in turn. A new sample is taken while a result waits.
// Reset (rst, synchronous): held quaternion cleared to zero, sequencer idle,
// no result pending.
`timescale 1ns / 1ps

module quaternion_to_euler_angles_core import q2e_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input logic          clk,
  input logic          rst,
  q2e_in_if.sink       sample,
  q2e_out_if.source    result
);

  localparam logic [3:0] IDX_YAW = 4'd0;
  localparam logic [3:0] IDX_PITCH = 4'd1;
  localparam logic [3:0] IDX_ROLL = 4'd2;
  localparam logic [3:0] IDX_SQ_LAST = 4'd2;
  localparam logic [3:0] IDX_PR_LAST = 4'd8;
  localparam logic signed [SUMW:0] T2_MAX = (SUMW + 1)'(64'd1073741824);
  localparam logic signed [CW-1:0] ONE_CW = CW'(64'd1073741824);

  state_t state, state_next;
  logic [3:0] idx;
  logic       issued;

  logic signed [QW-1:0] q1r, q2r, q3r;
  logic [WW-1:0]        hw;
  logic signed [QW-1:0] hx, hy, hz;
  logic [63:0]          sqacc;
  logic signed [SUMW-1:0] s0, s1, s2, s3, s4;
  logic [SW-1:0]        cval;
  logic [AW-1:0]        angmag;
  logic                 angneg;
  logic signed [YAWW-1:0] yaw, roll;
  logic signed [PITW-1:0] pitch;
  logic                 out_valid;

  logic accept, out_load;
  logic mul_start, mul_done, sqrt_start, sqrt_done, cord_start, cord_done;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic [RW-1:0]        rad;
  logic [SW-1:0]        root;
  logic signed [CW-1:0] cy, cx;
  logic signed [AW-1:0] cang;
  logic signed [SUMW-1:0] f;
  logic signed [SUMW:0]   t2full;
  logic signed [QW-1:0]   t2c;
  logic [47:0]          rsum;
  logic [YAWW-1:0]      rmag, rlim, rcl;
  logic signed [YAWW-1:0] rsig;

  function automatic logic signed [MW-1:0] sx(input logic signed [QW-1:0] v);
    return {v[QW-1], v};
  endfunction

  function automatic logic signed [CW-1:0] dbl(input logic signed [SUMW-1:0] v);
    return {v[SUMW-1], v, 1'b0};
  endfunction

  assign accept = sample.valid && sample.ready;
  assign f = {mul_p[PW-1], mul_p[PW-1:30]};
  assign t2full = {s2, 1'b0};
  assign t2c = (t2full > T2_MAX) ? QW'(T2_MAX) :
               (t2full < -T2_MAX) ? QW'(-T2_MAX) : t2full[QW-1:0];
  assign rad = (sqacc >= ONE_SQ) ? '0 : RW'(ONE_SQ - sqacc);

  assign rsum = mul_p[47:0] + 48'h0000_8000_0000;
  assign rmag = rsum[47:32];
  assign rlim = (idx == IDX_PITCH) ? PITCH_LIM : YAW_LIM;
  assign rcl  = (rmag > rlim) ? rlim : rmag;
  assign rsig = angneg ? -$signed(rcl) : $signed(rcl);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ_MUL: begin
        case (idx)
          4'd0:    mul_a = sx(q1r);
          4'd1:    mul_a = sx(q2r);
          default: mul_a = sx(q3r);
        endcase
        mul_b = mul_a;
      end
      ST_PR_MUL: begin
        case (idx)
          4'd0:    begin mul_a = {2'b00, hw}; mul_b = sx(hz); end
          4'd1:    begin mul_a = sx(hx);      mul_b = sx(hy); end
          4'd2:    begin mul_a = sx(hy);      mul_b = sx(hy); end
          4'd3:    begin mul_a = sx(hz);      mul_b = sx(hz); end
          4'd4:    begin mul_a = {2'b00, hw}; mul_b = sx(hy); end
          4'd5:    begin mul_a = sx(hx);      mul_b = sx(hz); end
          4'd6:    begin mul_a = {2'b00, hw}; mul_b = sx(hx); end
          4'd7:    begin mul_a = sx(hy);      mul_b = sx(hz); end
          default: begin mul_a = sx(hx);      mul_b = sx(hx); end
        endcase
      end
      ST_PT_MUL: begin
        mul_a = sx(t2c);
        mul_b = sx(t2c);
      end
      ST_CONV: begin
        mul_a = $signed(angmag);
        mul_b = MW'(CENTIDEG_PER_TURN);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // CORDIC argument select
  always_comb begin
    case (idx)
      IDX_YAW: begin
        cy = dbl(s3);
        cx = ONE_CW - dbl(s4);
      end
      IDX_PITCH: begin
        cy = {{(CW - QW){t2c[QW-1]}}, t2c};
        cx = {{(CW - SW){1'b0}}, cval};
      end
      default: begin
        cy = dbl(s0);
        cx = ONE_CW - dbl(s1);
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (accept) state_next = sample.quat_present ? ST_SQ_MUL : ST_PR_MUL;
      ST_SQ_MUL:  if (mul_done && idx == IDX_SQ_LAST) state_next = ST_SQ_ROOT;
      ST_SQ_ROOT: if (sqrt_done) state_next = ST_PR_MUL;
      ST_PR_MUL:  if (mul_done && idx == IDX_PR_LAST) state_next = ST_PT_MUL;
      ST_PT_MUL:  if (mul_done) state_next = ST_PT_ROOT;
      ST_PT_ROOT: if (sqrt_done) state_next = ST_CORD;
      ST_CORD:    if (cord_done) state_next = ST_CONV;
      ST_CONV:    if (mul_done) state_next = (idx == IDX_ROLL) ? ST_DONE : ST_CORD;
      ST_DONE:    if (out_load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    sample.ready = 1'b0;
    mul_start    = 1'b0;
    sqrt_start   = 1'b0;
    cord_start   = 1'b0;
    out_load     = 1'b0;
    case (state)
      ST_IDLE:                  sample.ready = 1'b1;
      ST_SQ_MUL, ST_PR_MUL,
      ST_PT_MUL, ST_CONV:       mul_start = !issued;
      ST_SQ_ROOT, ST_PT_ROOT:   sqrt_start = !issued;
      ST_CORD:                  cord_start = !issued;
      ST_DONE:                  out_load = !out_valid || result.ready;
      default:                  sample.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issued    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
      hw        <= '0;
      hx        <= '0;
      hy        <= '0;
      hz        <= '0;
    end else begin
      state <= state_next;
      if (mul_start || sqrt_start || cord_start) begin
        issued <= 1'b1;
      end else if (mul_done || sqrt_done || cord_done) begin
        issued <= 1'b0;
      end

      if (accept) begin
        q1r       <= sample.q1_raw;
        q2r       <= sample.q2_raw;
        q3r       <= sample.q3_raw;
        sqacc     <= '0;
        idx       <= '0;
      end

      if (state == ST_SQ_MUL && mul_done) begin
        sqacc <= sqacc + mul_p[63:0];
        idx   <= (idx == IDX_SQ_LAST) ? 4'd0 : idx + 4'd1;
      end

      if (state == ST_SQ_ROOT && sqrt_done) begin
        hw <= root;
        hx <= q2r;
        hy <= q1r;
        hz <= -q3r;
      end

      if (state == ST_PR_MUL && mul_done) begin
        case (idx)
          4'd0:    s3 <= f;
          4'd1:    s3 <= s3 + f;
          4'd2:    begin s4 <= f; s1 <= f; end
          4'd3:    s4 <= s4 + f;
          4'd4:    s2 <= f;
          4'd5:    s2 <= s2 - f;
          4'd6:    s0 <= f;
          4'd7:    s0 <= s0 + f;
          default: s1 <= s1 + f;
        endcase
        idx <= (idx == IDX_PR_LAST) ? 4'd0 : idx + 4'd1;
      end

      // reuse the square accumulator for the pitch cosine radicand
      if (state == ST_PT_MUL && mul_done) begin
        sqacc <= mul_p[63:0];
      end

      if (state == ST_PT_ROOT && sqrt_done) begin
        cval <= root;
      end

      if (state == ST_CORD && cord_done) begin
        angneg <= cang[AW-1];
        angmag <= cang[AW-1] ? AW'(-cang) : AW'(cang);
      end

      if (state == ST_CONV && mul_done) begin
        case (idx)
          IDX_YAW:   yaw <= rsig;
          IDX_PITCH: pitch <= rsig[PITW-1:0];
          default:   roll <= rsig;
        endcase
        idx <= (idx == IDX_ROLL) ? 4'd0 : idx + 4'd1;
      end

      // hold the result until the transfer completes
      if (out_load) begin
        out_valid             <= 1'b1;
        result.quat_w         <= hw;
        result.quat_x         <= hx;
        result.quat_y         <= hy;
        result.quat_z         <= hz;
        result.yaw_centideg   <= yaw;
        result.pitch_centideg <= pitch;
        result.roll_centideg  <= roll;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid = out_valid;

  q2e_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  q2e_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (rad),
    .done  (sqrt_done),
    .root  (root)
  );

  q2e_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .y_in  (cy),
    .x_in  (cx),
    .done  (cord_done),
    .ang   (cang)
  );

`ifndef NO_ASSERTIONS
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_done, sqrt_done, cord_done}))
    else $error("more than one arithmetic unit finished at once");

  a_mul_phase: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_SQ_MUL || state == ST_PR_MUL ||
                  state == ST_PT_MUL || state == ST_CONV))
    else $error("multiplier finished outside a multiply phase");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_load) |=> (state == ST_IDLE && out_valid))
    else $error("result not loaded on completion");
`endif

endmodule
